### sv/basic_dialect_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
`ifndef BASIC_DIALECT_TOKENIZER_ASSERT_SVH
`define BASIC_DIALECT_TOKENIZER_ASSERT_SVH

// Checks a property at every clock edge outside reset.
`define BDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define BDT_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

### sv/bdt_pkg.sv
// Shared types, codes and lexing functions for the tokenizer.
package bdt_pkg;

  // Lexer mode codes.
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_ALPHA1  = 4'd1;
  localparam logic [3:0] M_ALPHA2  = 4'd2;
  localparam logic [3:0] M_ZERO    = 4'd3;
  localparam logic [3:0] M_DEC     = 4'd4;
  localparam logic [3:0] M_HEX0    = 4'd5;
  localparam logic [3:0] M_HEX     = 4'd6;
  localparam logic [3:0] M_BIN0    = 4'd7;
  localparam logic [3:0] M_BIN     = 4'd8;
  localparam logic [3:0] M_OP2     = 4'd9;
  localparam logic [3:0] M_CHOPEN  = 4'd10;
  localparam logic [3:0] M_CHESC   = 4'd11;
  localparam logic [3:0] M_CHBODY  = 4'd12;
  localparam logic [3:0] M_STRING  = 4'd13;
  localparam logic [3:0] M_COMMENT = 4'd14;
  localparam logic [3:0] M_LABEL   = 4'd15;

  // Token type codes.
  localparam logic [6:0] TOK_NONE    = 7'd0;
  localparam logic [6:0] TOK_VAR_A   = 7'd24;
  localparam logic [6:0] TOK_HEX     = 7'd50;
  localparam logic [6:0] TOK_BIN     = 7'd51;
  localparam logic [6:0] TOK_DEC     = 7'd52;
  localparam logic [6:0] TOK_ADD     = 7'd53;
  localparam logic [6:0] TOK_SUB     = 7'd54;
  localparam logic [6:0] TOK_MUL     = 7'd55;
  localparam logic [6:0] TOK_DIV     = 7'd56;
  localparam logic [6:0] TOK_MOD     = 7'd57;
  localparam logic [6:0] TOK_AND     = 7'd58;
  localparam logic [6:0] TOK_LAND    = 7'd61;
  localparam logic [6:0] TOK_NOT     = 7'd64;
  localparam logic [6:0] TOK_EQ      = 7'd65;
  localparam logic [6:0] TOK_LT      = 7'd66;
  localparam logic [6:0] TOK_GT      = 7'd67;
  localparam logic [6:0] TOK_NE      = 7'd68;
  localparam logic [6:0] TOK_LPAREN  = 7'd69;
  localparam logic [6:0] TOK_RPAREN  = 7'd70;
  localparam logic [6:0] TOK_LBRACK  = 7'd71;
  localparam logic [6:0] TOK_RBRACK  = 7'd72;
  localparam logic [6:0] TOK_CHAR    = 7'd73;
  localparam logic [6:0] TOK_STRING  = 7'd74;
  localparam logic [6:0] TOK_COMMENT = 7'd75;
  localparam logic [6:0] TOK_LABEL   = 7'd76;

  // Highest offset; offsets saturate here.
  localparam logic [7:0] POS_MAX = 8'd255;

  // One result word.
  typedef struct packed {
    logic [6:0] token_type;
    logic [7:0] start_offset;
    logic [7:0] token_length;
    logic [7:0] token_index;
    logic       last;
  } token_t;

  // Outcome of handing one byte to the lexer in one mode.
  typedef struct packed {
    logic       consumed;
    logic       emit;
    logic       stop;
    logic [6:0] ttype;
    logic [8:0] end_pos;
    logic [3:0] mode;
    logic [7:0] la0;
    logic [7:0] la1;
    logic [7:0] ts;
  } feed_t;

  function automatic logic is_lower(logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7a);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return is_lower(c) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return is_lower(c) ? c - 8'd32 : c;
  endfunction

  // Keyword lookup: returns {is3, is2, code}.
  function automatic logic [6:0] kw_lookup(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [15:0] ab;
    logic [7:0]  cu;
    logic [4:0]  two;
    logic [4:0]  three;
    ab    = {to_upper(a), to_upper(b)};
    cu    = to_upper(c);
    two   = 5'd0;
    three = 5'd0;
    case (ab)
      16'h444f: begin two = 5'd1; if (cu == 8'h4e) three = 5'd2; end    // DO, DON
      16'h454c: if (cu == 8'h53) three = 5'd3;                          // ELS
      16'h4558: if (cu == 8'h45) three = 5'd4;                          // EXE
      16'h4946: two = 5'd5;                                             // IF
      16'h494e: begin two = 5'd6; if (cu == 8'h4e) three = 5'd7; end    // IN, INN
      16'h4a4d: if (cu == 8'h50) three = 5'd8;                          // JMP
      16'h4c45: if (cu == 8'h54) three = 5'd9;                          // LET
      16'h4f50: if (cu == 8'h4e) three = 5'd10;                         // OPN
      16'h4f55: if (cu == 8'h54) three = 5'd11;                         // OUT
      16'h5052: if (cu == 8'h54) three = 5'd12;                         // PRT
      16'h5244: begin two = 5'd13; if (cu == 8'h4e) three = 5'd14; end   // RD, RDN
      16'h5245: if (cu == 8'h51) three = 5'd15;                         // REQ
      16'h5254: if (cu == 8'h4e) three = 5'd16;                         // RTN
      16'h534c: if (cu == 8'h50) three = 5'd17;                         // SLP
      16'h5355: if (cu == 8'h42) three = 5'd18;                         // SUB
      16'h544f: begin
        if (cu == 8'h4e) three = 5'd19;                                 // TON
        if (cu == 8'h53) three = 5'd20;                                 // TOS
      end
      16'h5641: begin
        if (cu == 8'h4c) three = 5'd21;                                 // VAL
        if (cu == 8'h52) three = 5'd22;                                 // VAR
      end
      16'h5849: if (cu == 8'h54) three = 5'd23;                         // XIT
      default: two = 5'd0;
    endcase
    if (three != 5'd0) return {2'b10, three};
    if (two != 5'd0) return {2'b01, two};
    return 7'd0;
  endfunction

  // Single-byte operators and brackets; zero when not one.
  function automatic logic [6:0] single_op(logic [7:0] c);
    case (c)
      8'h2b:   return TOK_ADD;
      8'h2d:   return TOK_SUB;
      8'h2a:   return TOK_MUL;
      8'h2f:   return TOK_DIV;
      8'h25:   return TOK_MOD;
      8'h3d:   return TOK_EQ;
      8'h3c:   return TOK_LT;
      8'h3e:   return TOK_GT;
      8'h28:   return TOK_LPAREN;
      8'h29:   return TOK_RPAREN;
      8'h5b:   return TOK_LBRACK;
      8'h5d:   return TOK_RBRACK;
      default: return TOK_NONE;
    endcase
  endfunction

  // Token length from end and start offsets, capped at 255.
  function automatic logic [7:0] tok_len(logic [8:0] end_pos, logic [7:0] ts);
    logic [8:0] d;
    d = end_pos - {1'b0, ts};
    if (end_pos <= {1'b0, ts}) return 8'd0;
    if (d[8]) return 8'd255;
    return d[7:0];
  endfunction

  // Hands byte c at offset p to the lexer in the given mode.
  function automatic feed_t feed(logic [3:0] mode, logic [7:0] la0, logic [7:0] la1,
                                 logic [7:0] ts, logic [7:0] c, logic [7:0] p);
    feed_t      r;
    logic [8:0] p1;
    logic [6:0] op;
    logic [6:0] kw;
    logic [7:0] vi;
    logic [6:0] k;
    logic       lbl;
    p1         = {1'b0, p} + 9'd1;
    op         = single_op(c);
    kw         = kw_lookup(la0, la1, c);
    vi         = to_upper(la0) - 8'h41;
    k          = (la0 == 8'h26) ? 7'd0 : (la0 == 8'h7c) ? 7'd1 : 7'd2;
    lbl        = (mode == M_LABEL);
    r.consumed = 1'b1;
    r.emit     = 1'b0;
    r.stop     = 1'b0;
    r.ttype    = TOK_NONE;
    r.end_pos  = p1;
    r.mode     = mode;
    r.la0      = la0;
    r.la1      = la1;
    r.ts       = ts;
    case (mode)
      M_IDLE: begin
        if (!(c == 8'h20 || c == 8'h09)) begin
          r.ts = p;
          if (is_alpha(c)) begin
            r.la0 = c; r.mode = M_ALPHA1;
          end else if (is_digit(c)) begin
            r.mode = (c == 8'h30) ? M_ZERO : M_DEC;
          end else if (op != TOK_NONE) begin
            r.emit = 1'b1; r.ttype = op;
          end else if (c == 8'h26 || c == 8'h7c || c == 8'h5e || c == 8'h21) begin
            r.la0 = c; r.mode = M_OP2;
          end else if (c == 8'h27) begin
            r.mode = M_CHOPEN;
          end else if (c == 8'h22) begin
            r.mode = M_STRING;
          end else if (c == 8'h23) begin
            r.mode = M_COMMENT;
          end else if (c == 8'h3a) begin
            r.mode = M_LABEL;
          end else begin
            r.emit = 1'b1; r.stop = 1'b1;
          end
        end
      end
      M_ALPHA1: begin
        if (is_alpha(c)) begin
          r.la1 = c; r.mode = M_ALPHA2;
        end else begin
          r.emit = 1'b1; r.ttype = TOK_VAR_A + 7'(vi[4:0]);
          r.end_pos = {1'b0, p}; r.mode = M_IDLE; r.consumed = 1'b0;
        end
      end
      M_ALPHA2: begin
        r.emit = 1'b1; r.mode = M_IDLE;
        if (kw[6]) begin
          r.ttype = {2'b00, kw[4:0]};
        end else if (kw[5]) begin
          r.ttype = {2'b00, kw[4:0]}; r.end_pos = {1'b0, p}; r.consumed = 1'b0;
        end else begin
          r.stop = 1'b1; r.end_pos = {1'b0, ts};
        end
      end
      M_ZERO, M_DEC: begin
        if (mode == M_ZERO && c == 8'h78) begin
          r.mode = M_HEX0;
        end else if (mode == M_ZERO && c == 8'h62) begin
          r.mode = M_BIN0;
        end else if (is_digit(c)) begin
          r.mode = M_DEC;
        end else begin
          r.emit = 1'b1; r.ttype = TOK_DEC; r.end_pos = {1'b0, p};
          r.mode = M_IDLE; r.consumed = 1'b0;
        end
      end
      M_HEX0: begin
        if (is_hex(c)) begin
          r.mode = M_HEX;
        end else begin
          r.emit = 1'b1; r.stop = 1'b1; r.end_pos = {1'b0, p}; r.mode = M_IDLE;
        end
      end
      M_BIN0: begin
        if (c == 8'h30 || c == 8'h31) begin
          r.mode = M_BIN;
        end else begin
          r.emit = 1'b1; r.stop = 1'b1; r.end_pos = {1'b0, p}; r.mode = M_IDLE;
        end
      end
      M_HEX: begin
        if (!is_hex(c)) begin
          r.emit = 1'b1; r.ttype = TOK_HEX; r.end_pos = {1'b0, p};
          r.mode = M_IDLE; r.consumed = 1'b0;
        end
      end
      M_BIN: begin
        if (!(c == 8'h30 || c == 8'h31)) begin
          r.emit = 1'b1; r.ttype = TOK_BIN; r.end_pos = {1'b0, p};
          r.mode = M_IDLE; r.consumed = 1'b0;
        end
      end
      M_OP2: begin
        r.emit = 1'b1; r.mode = M_IDLE;
        if (la0 == 8'h21) begin
          if (c == 8'h3d) begin
            r.ttype = TOK_NE;
          end else begin
            r.ttype = TOK_NOT; r.end_pos = {1'b0, p}; r.consumed = 1'b0;
          end
        end else if (c == la0) begin
          r.ttype = TOK_LAND + k;
        end else begin
          r.ttype = TOK_AND + k; r.end_pos = {1'b0, p}; r.consumed = 1'b0;
        end
      end
      M_CHOPEN, M_CHESC: begin
        if (c == 8'h00) begin
          r.emit = 1'b1; r.stop = 1'b1; r.mode = M_IDLE;
        end else begin
          r.mode = (mode == M_CHOPEN && c == 8'h5c) ? M_CHESC : M_CHBODY;
        end
      end
      M_CHBODY: begin
        r.emit = 1'b1; r.mode = M_IDLE;
        if (c == 8'h27) r.ttype = TOK_CHAR;
        else r.stop = 1'b1;
      end
      M_STRING: begin
        if (c == 8'h22) begin
          r.emit = 1'b1; r.ttype = TOK_STRING; r.mode = M_IDLE;
        end else if (c == 8'h00) begin
          r.emit = 1'b1; r.stop = 1'b1; r.mode = M_IDLE;
        end
      end
      M_COMMENT, M_LABEL: begin
        if (c == 8'h00) begin
          r.emit = 1'b1; r.ttype = lbl ? TOK_LABEL : TOK_COMMENT;
          r.end_pos = {1'b0, p}; r.mode = M_IDLE; r.consumed = 1'b0;
        end else if (c == 8'h0a || (lbl && (c == 8'h20 || c == 8'h09))) begin
          r.emit = 1'b1; r.ttype = lbl ? TOK_LABEL : TOK_COMMENT; r.mode = M_IDLE;
        end
      end
      default: begin
        r.mode = M_IDLE; r.consumed = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

### sv/bdt_in_if.sv
// Source byte channel: one byte per word.
interface bdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

### sv/bdt_out_if.sv
// Token channel: one token per word.
interface bdt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] token_type;
  logic [7:0] start_offset;
  logic [7:0] token_length;
  logic [7:0] token_index;
  logic       last;

  modport source (output valid, output token_type, output start_offset,
                  output token_length, output token_index, output last, input ready);
  modport sink (input valid, input token_type, input start_offset,
                input token_length, input token_index, input last, output ready);
endinterface

### sv/bdt_out_fifo.sv
// Four-word token queue that takes up to two words per cycle.
`include "basic_dialect_tokenizer_assert.svh"

module bdt_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  bdt_pkg::token_t   push_a,
  input  bdt_pkg::token_t   push_b,
  output logic [2:0]        count,
  bdt_out_if.source         out_w
);

  bdt_pkg::token_t buf_r [4];
  logic [1:0]      wp_r;
  logic [1:0]      rp_r;
  logic [2:0]      cnt_r;
  logic            pop;
  bdt_pkg::token_t head;

  assign pop   = out_w.valid && out_w.ready;
  assign count = cnt_r;
  assign head  = buf_r[rp_r];

  // Head word drives the channel.
  assign out_w.valid        = (cnt_r != 3'd0);
  assign out_w.token_type   = head.token_type;
  assign out_w.start_offset = head.start_offset;
  assign out_w.token_length = head.token_length;
  assign out_w.token_index  = head.token_index;
  assign out_w.last         = head.last;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) buf_r[wp_r] <= push_a;
    if (push_n == 2'd2) buf_r[wp_r + 2'd1] <= push_b;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_r + push_n;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push_n} - {2'b00, pop};
    end
  end

  `BDT_ASSERT(a_cnt_bound, cnt_r <= 3'd4, "token queue overfilled")
  `BDT_ASSERT(a_push_room, (push_n != 2'd0) |-> (cnt_r <= 3'd2), "push without room")
  `BDT_ASSERT_NEXT(a_cnt_track, 1'b1, cnt_r == $past(cnt_r + {1'b0, push_n} - {2'b00, pop}), "count mismatch")

endmodule

### sv/basic_dialect_tokenizer.sv
// Streaming tokenizer for a small BASIC-like dialect: top level.
//
// in_w carries source bytes, one per word; a zero byte ends a source.
// out_w carries tokens (type, start offset, length, index, last flag).
// The lexer state and each byte taken pass through the combinational lexer
// step (fed again from idle if not consumed); the resulting zero, one or
// two tokens are written into a four-word output queue in the same cycle.
// With out_w ready and at most two words queued, one byte is accepted every
// cycle. A byte that closes one token and starts another that it also ends
// (or the end byte after a comment) yields two tokens. in_w.ready is high
// while the queue holds at most two words, so the input keeps flowing while
// one finished token waits; when the receiver stalls, input stops once more
// than two tokens are queued and resumes as they drain. After the final
// none token the block drops bytes up to the zero byte.
// Reset (rst_n low, synchronous) empties the queue and restarts the lexer
// at offset zero with the token count cleared.
module basic_dialect_tokenizer (
  input  logic clk,
  input  logic rst_n,
  bdt_in_if.sink     in_w,
  bdt_out_if.source  out_w
);

  logic [7:0] pos_r;
  logic [7:0] ts_r;
  logic [3:0] mode_r;
  logic [7:0] la0_r;
  logic [7:0] la1_r;
  logic [7:0] idx_r;
  logic       stopped_r;

  logic              take;
  logic [7:0]        c;
  bdt_pkg::feed_t    f1;
  bdt_pkg::feed_t    f2;
  bdt_pkg::feed_t    fin;
  logic              e1;
  logic              e2;
  logic [7:0]        idx1;
  logic [7:0]        idx_nxt;
  bdt_pkg::token_t   t1;
  bdt_pkg::token_t   t2;
  logic [1:0]        push_n;
  bdt_pkg::token_t   push_a;
  logic [2:0]        qcount;

  assign in_w.ready = (qcount <= 3'd2);
  assign take       = in_w.valid && in_w.ready;
  assign c          = in_w.ch;

  // Lexer step: a byte that is not consumed is fed again from idle.
  always_comb begin
    f1  = bdt_pkg::feed(mode_r, la0_r, la1_r, ts_r, c, pos_r);
    f2  = bdt_pkg::feed(f1.mode, f1.la0, f1.la1, f1.ts, c, pos_r);
    fin = f1.consumed ? f1 : f2;
    e1  = take && !stopped_r && f1.emit;
    e2  = take && !stopped_r && !f1.consumed && f2.emit;
  end

  // Token words and running index.
  always_comb begin
    idx1    = (e1 && idx_r != 8'd255) ? idx_r + 8'd1 : idx_r;
    idx_nxt = (e2 && idx1 != 8'd255) ? idx1 + 8'd1 : idx1;
    t1.token_type   = f1.ttype;
    t1.start_offset = f1.ts;
    t1.token_length = bdt_pkg::tok_len(f1.end_pos, f1.ts);
    t1.token_index  = idx_r;
    t1.last         = f1.stop;
    t2.token_type   = f2.ttype;
    t2.start_offset = f2.ts;
    t2.token_length = bdt_pkg::tok_len(f2.end_pos, f2.ts);
    t2.token_index  = idx1;
    t2.last         = f2.stop;
    push_n = {1'b0, e1} + {1'b0, e2};
    push_a = e1 ? t1 : t2;
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 8'd0;
      ts_r      <= 8'd0;
      mode_r    <= bdt_pkg::M_IDLE;
      la0_r     <= 8'd0;
      la1_r     <= 8'd0;
      idx_r     <= 8'd0;
      stopped_r <= 1'b0;
    end else if (take) begin
      if (c == 8'h00) begin
        pos_r     <= 8'd0;
        ts_r      <= 8'd0;
        mode_r    <= bdt_pkg::M_IDLE;
        la0_r     <= 8'd0;
        la1_r     <= 8'd0;
        idx_r     <= 8'd0;
        stopped_r <= 1'b0;
      end else if (!stopped_r) begin
        if (pos_r != bdt_pkg::POS_MAX) pos_r <= pos_r + 8'd1;
        ts_r      <= fin.ts;
        mode_r    <= fin.mode;
        la0_r     <= fin.la0;
        la1_r     <= fin.la1;
        idx_r     <= idx_nxt;
        stopped_r <= (e1 && f1.stop) || (e2 && f2.stop);
      end
    end
  end

  bdt_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .push_a (push_a),
    .push_b (t2),
    .count  (qcount),
    .out_w  (out_w)
  );

endmodule
